// ===== rtl/core/pct_pkg.sv =====
package pct_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;
    localparam int IN_COORD_W = 16;
    localparam int ID_W       = 16;
    localparam int KEEP_W     = 6;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ORIENT_W   = PROD_W + 1;

    localparam logic FUNC_ADD     = 1'b0;
    localparam logic FUNC_TRIM    = 1'b1;
    localparam logic SIDE_LEFT    = 1'b0;
    localparam logic SIDE_RIGHT   = 1'b1;
    localparam logic KIND_NODE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } xy_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        xy_t             pos;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    // candidate cuts travel with a segment pair through the crossing pipe
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] lcand;
        logic [CNT_W-1:0] rcand;
    } pair_tag_t;

endpackage

// ===== rtl/core/pct_ram.sv =====
module pct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pct_cross.sv =====
module pct_cross (
    input  logic               clk,
    input  logic               rst_n,
    input  pct_pkg::xy_t       a,
    input  pct_pkg::xy_t       b,
    input  pct_pkg::xy_t       c,
    input  pct_pkg::xy_t       d,
    input  pct_pkg::pair_tag_t tag_in,
    output pct_pkg::pair_tag_t hit,
    output logic               busy
);
    import pct_pkg::*;

    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ORIENT_W-1:0] orient_t;

    diff_t     ux_next [4];
    diff_t     uy_next [4];
    diff_t     vx_next [4];
    diff_t     vy_next [4];
    diff_t     ux_reg  [4];
    diff_t     uy_reg  [4];
    diff_t     vx_reg  [4];
    diff_t     vy_reg  [4];
    prod_t     pl_reg  [4];
    prod_t     pr_reg  [4];
    orient_t   ov      [4];
    logic      is_pos  [4];
    logic      is_neg  [4];
    logic      cross_hit;
    pair_tag_t tag1_reg;
    pair_tag_t tag2_reg;
    pair_tag_t hit_reg;

    // orientations: c and d against ab, then a and b against cd
    always_comb
    begin
        ux_next[0] = diff_t'(b.x) - diff_t'(a.x);
        uy_next[0] = diff_t'(b.y) - diff_t'(a.y);
        vx_next[0] = diff_t'(c.x) - diff_t'(a.x);
        vy_next[0] = diff_t'(c.y) - diff_t'(a.y);
        ux_next[1] = ux_next[0];
        uy_next[1] = uy_next[0];
        vx_next[1] = diff_t'(d.x) - diff_t'(a.x);
        vy_next[1] = diff_t'(d.y) - diff_t'(a.y);
        ux_next[2] = diff_t'(d.x) - diff_t'(c.x);
        uy_next[2] = diff_t'(d.y) - diff_t'(c.y);
        vx_next[2] = diff_t'(a.x) - diff_t'(c.x);
        vy_next[2] = diff_t'(a.y) - diff_t'(c.y);
        ux_next[3] = ux_next[2];
        uy_next[3] = uy_next[2];
        vx_next[3] = diff_t'(b.x) - diff_t'(c.x);
        vy_next[3] = diff_t'(b.y) - diff_t'(c.y);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            ux_reg[k] <= ux_next[k];
            uy_reg[k] <= uy_next[k];
            vx_reg[k] <= vx_next[k];
            vy_reg[k] <= vy_next[k];
            pl_reg[k] <= prod_t'(ux_reg[k]) * prod_t'(vy_reg[k]);
            pr_reg[k] <= prod_t'(uy_reg[k]) * prod_t'(vx_reg[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ov[k]     = orient_t'(pl_reg[k]) - orient_t'(pr_reg[k]);
            is_neg[k] = ov[k][ORIENT_W-1];
            is_pos[k] = !ov[k][ORIENT_W-1] && (ov[k] != '0);
        end
        cross_hit = ((is_pos[0] && is_neg[1]) || (is_neg[0] && is_pos[1]))
                 && ((is_pos[2] && is_neg[3]) || (is_neg[2] && is_pos[3]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            hit_reg  <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            hit_reg  <= '{valid: tag2_reg.valid && cross_hit,
                          lcand: tag2_reg.lcand,
                          rcand: tag2_reg.rcand};
        end
    end

    assign hit  = hit_reg;
    assign busy = tag1_reg.valid || tag2_reg.valid || hit_reg.valid;

endmodule

// ===== rtl/core/polyline_crossing_trim.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    func side pos_x pos_y node_id
// out      output     out_valid / out_stall  kind removed_side removed_node
//                                            left_keep right_keep crossed
//                                            overflowed last
//
// points live in one memory per line
// compute reads, for each left segment, its two left points and then every
// right point, one right memory read per cycle, then drains the crossing pipe;
// then each removed node is emitted, followed by the summary
// reset clears counts, overflow flag and control; the memories are not cleared
// out_stall holds the emission; in_stall is high from compute until the summary
// has been loaded into the output register
module polyline_crossing_trim (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic                                side,
    input  logic signed [pct_pkg::IN_COORD_W-1:0] pos_x,
    input  logic signed [pct_pkg::IN_COORD_W-1:0] pos_y,
    input  logic [pct_pkg::ID_W-1:0]            node_id,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                kind,
    output logic                                removed_side,
    output logic [pct_pkg::ID_W-1:0]            removed_node,
    output logic [pct_pkg::KEEP_W-1:0]          left_keep,
    output logic [pct_pkg::KEEP_W-1:0]          right_keep,
    output logic                                crossed,
    output logic                                overflowed,
    output logic                                last
);
    import pct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LA,
        S_LB,
        S_RB,
        S_RJ,
        S_DRAIN,
        S_LRD,
        S_LOUT,
        S_RRD,
        S_ROUT,
        S_SUM
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   left_cnt_reg;
    logic [CNT_W-1:0]   right_cnt_reg;
    logic               drop_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [CNT_W-1:0]   jr_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   lcut_reg;
    logic [CNT_W-1:0]   rcut_reg;
    logic               crossed_reg;
    xy_t                a_reg;
    xy_t                b_reg;
    xy_t                c_reg;

    logic               out_valid_reg;
    logic               kind_reg;
    logic               removed_side_reg;
    logic [ID_W-1:0]    removed_node_reg;
    logic [KEEP_W-1:0]  left_keep_reg;
    logic [KEEP_W-1:0]  right_keep_reg;
    logic               crossed_out_reg;
    logic               overflowed_reg;
    logic               last_reg;

    logic               in_fire;
    logic               out_free;
    logic               out_load;
    logic               left_full;
    logic               right_full;
    point_t             wr_point;
    logic               l_we;
    logic               r_we;
    logic               l_re;
    logic               r_re;
    logic [IDX_W-1:0]   l_raddr;
    logic [IDX_W-1:0]   r_raddr;
    logic [POINT_W-1:0] l_rdata_raw;
    logic [POINT_W-1:0] r_rdata_raw;
    point_t             l_rdata;
    point_t             r_rdata;
    pair_tag_t          pair_tag;
    pair_tag_t          hit;
    logic               busy;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = out_free && (state_reg inside {S_LOUT, S_ROUT, S_SUM});
    assign left_full  = (left_cnt_reg >= CNT_W'(MAX_POINTS));
    assign right_full = (right_cnt_reg >= CNT_W'(MAX_POINTS));

    always_comb
    begin
        wr_point.id    = node_id;
        wr_point.pos.x = coord_t'(unsigned'(pos_x));
        wr_point.pos.y = coord_t'(unsigned'(pos_y));
    end

    assign l_we = in_fire && (func == FUNC_ADD) && (side == SIDE_LEFT) && !left_full;
    assign r_we = in_fire && (func == FUNC_ADD) && (side == SIDE_RIGHT) && !right_full;

    always_comb
    begin
        l_re    = 1'b0;
        l_raddr = i_reg;
        r_re    = 1'b0;
        r_raddr = jr_reg[IDX_W-1:0];
        case (state_reg)
            S_LA:
            begin
                l_re = 1'b1;
            end
            S_LB:
            begin
                l_re    = 1'b1;
                l_raddr = i_reg + IDX_W'(1);
            end
            S_LRD:
            begin
                l_re    = (k_reg < left_cnt_reg);
                l_raddr = k_reg[IDX_W-1:0];
            end
            S_RB:
            begin
                r_re    = 1'b1;
                r_raddr = '0;
            end
            S_RJ:
            begin
                r_re = (jr_reg < right_cnt_reg);
            end
            S_RRD:
            begin
                r_re    = (k_reg < right_cnt_reg);
                r_raddr = k_reg[IDX_W-1:0];
            end
            default:
            begin
                l_re = 1'b0;
            end
        endcase
    end

    pct_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (left_cnt_reg[IDX_W-1:0]),
        .wdata (wr_point),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata_raw)
    );

    pct_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (right_cnt_reg[IDX_W-1:0]),
        .wdata (wr_point),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata_raw)
    );

    assign l_rdata = point_t'(l_rdata_raw);
    assign r_rdata = point_t'(r_rdata_raw);

    // pair j = jr-2 is complete once right point j+1 has been read
    always_comb
    begin
        pair_tag.valid = (state_reg == S_RJ) && (jr_reg >= CNT_W'(2));
        pair_tag.lcand = CNT_W'(i_reg) + CNT_W'(1);
        pair_tag.rcand = jr_reg - CNT_W'(1);
    end

    pct_cross u_cross (
        .clk    (clk),
        .rst_n  (rst_n),
        .a      (a_reg),
        .b      (b_reg),
        .c      (c_reg),
        .d      (r_rdata.pos),
        .tag_in (pair_tag),
        .hit    (hit),
        .busy   (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            jr_reg        <= '0;
            k_reg         <= '0;
            lcut_reg      <= '0;
            rcut_reg      <= '0;
            crossed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (hit.valid)
            begin
                crossed_reg <= 1'b1;
                if (hit.lcand < lcut_reg)
                begin
                    lcut_reg <= hit.lcand;
                end
                if (hit.rcand < rcut_reg)
                begin
                    rcut_reg <= hit.rcand;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (func == FUNC_ADD)
                        begin
                            if (side == SIDE_LEFT)
                            begin
                                if (left_full)
                                begin
                                    drop_reg <= 1'b1;
                                end
                                else
                                begin
                                    left_cnt_reg <= left_cnt_reg + CNT_W'(1);
                                end
                            end
                            else
                            begin
                                if (right_full)
                                begin
                                    drop_reg <= 1'b1;
                                end
                                else
                                begin
                                    right_cnt_reg <= right_cnt_reg + CNT_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            lcut_reg    <= left_cnt_reg;
                            rcut_reg    <= right_cnt_reg;
                            crossed_reg <= 1'b0;
                            i_reg       <= '0;
                            k_reg       <= left_cnt_reg;
                            if ((left_cnt_reg >= CNT_W'(2)) && (right_cnt_reg >= CNT_W'(2)))
                            begin
                                state_reg <= S_LA;
                            end
                            else
                            begin
                                state_reg <= S_LRD;
                            end
                        end
                    end
                end
                S_LA:
                begin
                    state_reg <= S_LB;
                end
                S_LB:
                begin
                    a_reg     <= l_rdata.pos;
                    state_reg <= S_RB;
                end
                S_RB:
                begin
                    b_reg     <= l_rdata.pos;
                    jr_reg    <= CNT_W'(1);
                    state_reg <= S_RJ;
                end
                S_RJ:
                begin
                    c_reg  <= r_rdata.pos;
                    jr_reg <= jr_reg + CNT_W'(1);
                    if (jr_reg == right_cnt_reg)
                    begin
                        if (CNT_W'(i_reg) + CNT_W'(2) < left_cnt_reg)
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= S_LA;
                        end
                        else
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!busy)
                    begin
                        k_reg     <= lcut_reg;
                        state_reg <= S_LRD;
                    end
                end
                S_LRD:
                begin
                    if (k_reg < left_cnt_reg)
                    begin
                        state_reg <= S_LOUT;
                    end
                    else
                    begin
                        k_reg     <= rcut_reg;
                        state_reg <= S_RRD;
                    end
                end
                S_LOUT:
                begin
                    if (out_free)
                    begin
                        kind_reg         <= KIND_NODE;
                        removed_side_reg <= SIDE_LEFT;
                        removed_node_reg <= l_rdata.id;
                        left_keep_reg    <= '0;
                        right_keep_reg   <= '0;
                        crossed_out_reg  <= 1'b0;
                        overflowed_reg   <= 1'b0;
                        last_reg         <= 1'b0;
                        k_reg            <= k_reg + CNT_W'(1);
                        state_reg        <= S_LRD;
                    end
                end
                S_RRD:
                begin
                    if (k_reg < right_cnt_reg)
                    begin
                        state_reg <= S_ROUT;
                    end
                    else
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_ROUT:
                begin
                    if (out_free)
                    begin
                        kind_reg         <= KIND_NODE;
                        removed_side_reg <= SIDE_RIGHT;
                        removed_node_reg <= r_rdata.id;
                        left_keep_reg    <= '0;
                        right_keep_reg   <= '0;
                        crossed_out_reg  <= 1'b0;
                        overflowed_reg   <= 1'b0;
                        last_reg         <= 1'b0;
                        k_reg            <= k_reg + CNT_W'(1);
                        state_reg        <= S_RRD;
                    end
                end
                S_SUM:
                begin
                    if (out_free)
                    begin
                        kind_reg         <= KIND_SUMMARY;
                        removed_side_reg <= 1'b0;
                        removed_node_reg <= '0;
                        left_keep_reg    <= KEEP_W'(lcut_reg);
                        right_keep_reg   <= KEEP_W'(rcut_reg);
                        crossed_out_reg  <= crossed_reg;
                        overflowed_reg   <= drop_reg;
                        last_reg         <= 1'b1;
                        left_cnt_reg     <= '0;
                        right_cnt_reg    <= '0;
                        drop_reg         <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign removed_side = removed_side_reg;
    assign removed_node = removed_node_reg;
    assign left_keep    = left_keep_reg;
    assign right_keep   = right_keep_reg;
    assign crossed      = crossed_out_reg;
    assign overflowed   = overflowed_reg;
    assign last         = last_reg;

endmodule

// ===== tb/polyline_crossing_trim_tb.sv =====
module polyline_crossing_trim_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pct_pkg::*;

    localparam int RANDOM_ITEMS  = 440;
    localparam int MAX_GAP       = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 50;

    typedef logic signed [IN_COORD_W-1:0] in_coord_t;

    typedef struct packed {
        logic              kind;
        logic              rside;
        logic [ID_W-1:0]   node;
        logic [KEEP_W-1:0] lkeep;
        logic [KEEP_W-1:0] rkeep;
        logic              cr;
        logic              ov;
        logic              last;
    } trim_report_t;

    typedef struct packed {
        logic              func;
        logic              side;
        in_coord_t         x;
        in_coord_t         y;
        logic [ID_W-1:0]   id;
        logic              typed;
        logic [KEEP_W-1:0] lkeep;
        logic [KEEP_W-1:0] rkeep;
        logic              cr;
        logic              ov;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              func = 1'b0;
    logic              side = 1'b0;
    in_coord_t         pos_x = '0;
    in_coord_t         pos_y = '0;
    logic [ID_W-1:0]   node_id = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              kind;
    logic              removed_side;
    logic [ID_W-1:0]   removed_node;
    logic [KEEP_W-1:0] left_keep;
    logic [KEEP_W-1:0] right_keep;
    logic              crossed;
    logic              overflowed;
    logic              last;

    // line contents as the block should hold them
    coord_t          left_x [MAX_POINTS];
    coord_t          left_y [MAX_POINTS];
    logic [ID_W-1:0] left_id [MAX_POINTS];
    coord_t          right_x [MAX_POINTS];
    coord_t          right_y [MAX_POINTS];
    logic [ID_W-1:0] right_id [MAX_POINTS];
    int              left_n = 0;
    int              right_n = 0;
    logic            points_dropped = 1'b0;

    trim_report_t expected_reports[$];
    stim_row_t    directed[$];

    int   errors = 0;
    int   n_items = 0;
    int   n_results = 0;
    int   n_trims = 0;
    int   n_crossed = 0;
    int   n_overflowed = 0;
    int   n_removed = 0;
    logic tx_steady = 1'b0;

    polyline_crossing_trim i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .side         (side),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .node_id      (node_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .removed_side (removed_side),
        .removed_node (removed_node),
        .left_keep    (left_keep),
        .right_keep   (right_keep),
        .crossed      (crossed),
        .overflowed   (overflowed),
        .last         (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void expect_report(trim_report_t r);
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    function automatic void add_row(stim_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    function automatic int orient_sign(input coord_t ax, input coord_t ay,
                                       input coord_t bx, input coord_t by,
                                       input coord_t cx, input coord_t cy);
        longint v;
        v = (longint'(bx) - longint'(ax)) * (longint'(cy) - longint'(ay))
          - (longint'(by) - longint'(ay)) * (longint'(cx) - longint'(ax));
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic logic segs_cross(int i, int j);
        int s1;
        int s2;
        int s3;
        int s4;
        s1 = orient_sign(left_x[i], left_y[i], left_x[i+1], left_y[i+1], right_x[j], right_y[j]);
        s2 = orient_sign(left_x[i], left_y[i], left_x[i+1], left_y[i+1],
                         right_x[j+1], right_y[j+1]);
        s3 = orient_sign(right_x[j], right_y[j], right_x[j+1], right_y[j+1], left_x[i], left_y[i]);
        s4 = orient_sign(right_x[j], right_y[j], right_x[j+1], right_y[j+1],
                         left_x[i+1], left_y[i+1]);
        return (s1 * s2 < 0) && (s3 * s4 < 0);
    endfunction

    task automatic predict_trim(stim_row_t item);
        int           lcut;
        int           rcut;
        logic         hit;
        trim_report_t r;
        if (item.func == FUNC_ADD)
        begin
            if (item.side == SIDE_LEFT)
            begin
                if (left_n < MAX_POINTS)
                begin
                    left_x[left_n] = item.x[COORD_BITS-1:0];
                    left_y[left_n] = item.y[COORD_BITS-1:0];
                    left_id[left_n] = item.id;
                    left_n++;
                end
                else
                begin
                    points_dropped = 1'b1;
                end
            end
            else
            begin
                if (right_n < MAX_POINTS)
                begin
                    right_x[right_n] = item.x[COORD_BITS-1:0];
                    right_y[right_n] = item.y[COORD_BITS-1:0];
                    right_id[right_n] = item.id;
                    right_n++;
                end
                else
                begin
                    points_dropped = 1'b1;
                end
            end
        end
        else
        begin
            lcut = left_n;
            rcut = right_n;
            hit = 1'b0;
            if (left_n >= 2 && right_n >= 2)
            begin
                for (int i = 0; i + 1 < left_n; i++)
                begin
                    for (int j = 0; j + 1 < right_n; j++)
                    begin
                        if (segs_cross(i, j))
                        begin
                            hit = 1'b1;
                            if (i + 1 < lcut)
                                lcut = i + 1;
                            if (j + 1 < rcut)
                                rcut = j + 1;
                        end
                    end
                end
            end
            if (hit)
            begin
                for (int k = lcut; k < left_n; k++)
                begin
                    r = '0;
                    r.kind = KIND_NODE;
                    r.rside = SIDE_LEFT;
                    r.node = left_id[k];
                    expect_report(r);
                end
                for (int k = rcut; k < right_n; k++)
                begin
                    r = '0;
                    r.kind = KIND_NODE;
                    r.rside = SIDE_RIGHT;
                    r.node = right_id[k];
                    expect_report(r);
                end
                n_crossed++;
                n_removed += (left_n - lcut) + (right_n - rcut);
            end
            r = '0;
            r.kind = KIND_SUMMARY;
            r.lkeep = KEEP_W'(lcut);
            r.rkeep = KEEP_W'(rcut);
            r.cr = hit;
            r.ov = points_dropped;
            r.last = 1'b1;
            expect_report(r);
            if (points_dropped)
                n_overflowed++;
            n_trims++;
            left_n = 0;
            right_n = 0;
            points_dropped = 1'b0;
        end
    endtask

    function automatic stim_row_t point_row(logic s, in_coord_t x, in_coord_t y,
                                            logic [ID_W-1:0] id);
        stim_row_t r;
        r = '0;
        r.func = FUNC_ADD;
        r.side = s;
        r.x = x;
        r.y = y;
        r.id = id;
        return r;
    endfunction

    function automatic stim_row_t trim_row(logic s, in_coord_t x, in_coord_t y,
                                           logic [ID_W-1:0] id, logic typed,
                                           int lk, int rk, logic cr, logic ov);
        stim_row_t r;
        r = point_row(s, x, y, id);
        r.func = FUNC_TRIM;
        r.typed = typed;
        r.lkeep = KEEP_W'(lk);
        r.rkeep = KEEP_W'(rk);
        r.cr = cr;
        r.ov = ov;
        return r;
    endfunction

    task automatic send_item(stim_row_t row);
        int           gap;
        trim_report_t t;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 29) == 0)
            tx_steady = !tx_steady;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= row.func;
        side <= row.side;
        pos_x <= row.x;
        pos_y <= row.y;
        node_id <= row.id;
        do
            @(posedge clk);
        while (in_stall);
        n_items++;
        predict_trim(row);
        if (row.typed)
        begin
            void'(expected_reports.pop_back());
            t = '0;
            t.kind = KIND_SUMMARY;
            t.lkeep = row.lkeep;
            t.rkeep = row.rkeep;
            t.cr = row.cr;
            t.ov = row.ov;
            t.last = 1'b1;
            expect_report(t);
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom_range(0, 1);
        if (r < 80)
            return $urandom_range(2, 8);
        if (r < 95)
            return $urandom_range(9, MAX_POINTS);
        return $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
    endfunction

    // small spread crosses often, a tight grid gives touching and collinear pairs
    function automatic in_coord_t rand_coord(int spread);
        if (spread < 6)
            return IN_COORD_W'($urandom_range(0, 128) - 64);
        if (spread < 8)
            return IN_COORD_W'($urandom_range(0, 6) - 3);
        return IN_COORD_W'($urandom);
    endfunction

    task automatic random_lines(logic fill_up);
        int want_l;
        int want_r;
        int spread;
        want_l = fill_up ? MAX_POINTS + 2 : pick_length();
        want_r = fill_up ? MAX_POINTS + 1 : pick_length();
        spread = $urandom_range(0, 9);
        while (want_l + want_r > 0)
        begin
            if (want_r == 0 || (want_l != 0 && $urandom_range(0, 1) == 0))
            begin
                send_item(point_row(SIDE_LEFT, rand_coord(spread), rand_coord(spread),
                                    ID_W'($urandom)));
                want_l--;
            end
            else
            begin
                send_item(point_row(SIDE_RIGHT, rand_coord(spread), rand_coord(spread),
                                    ID_W'($urandom)));
                want_r--;
            end
        end
        send_item(trim_row(1'($urandom), IN_COORD_W'($urandom), IN_COORD_W'($urandom),
                           ID_W'($urandom), 1'b0, 0, 0, 1'b0, 1'b0));
    endtask

    function automatic void check_field(string what, logic [ID_W-1:0] want,
                                        logic [ID_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    initial
    begin : receiver
        int           stall_left;
        logic         rx_steady;
        trim_report_t want;
        stall_left = 0;
        rx_steady = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, kind %0d node %0d",
                             $time, kind, removed_node);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("kind", ID_W'(want.kind), ID_W'(kind));
                    check_field("removed_side", ID_W'(want.rside), ID_W'(removed_side));
                    check_field("removed_node", want.node, removed_node);
                    check_field("left_keep", ID_W'(want.lkeep), ID_W'(left_keep));
                    check_field("right_keep", ID_W'(want.rkeep), ID_W'(right_keep));
                    check_field("crossed", ID_W'(want.cr), ID_W'(crossed));
                    check_field("overflowed", ID_W'(want.ov), ID_W'(overflowed));
                    check_field("last", ID_W'(want.last), ID_W'(last));
                end
                // long hold-offs let the block fill up and stall its input
                if (n_results == 30 || n_results == 150)
                    stall_left = HOLD_CYCLES;
                else
                    stall_left = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 29) == 0)
                    rx_steady = !rx_steady;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int n_seq;
        int random_base;
        n_seq = 0;

        // empty lines
        add_row(trim_row(SIDE_RIGHT, 16'h7fff, 16'h8000, 16'hffff,
                         1'b1, 0, 0, 1'b0, 1'b0));
        // right line too short
        add_row(point_row(SIDE_LEFT, 16'h8000, 16'h7fff, 16'h0000));
        add_row(point_row(SIDE_LEFT, 16'h7fff, 16'h8000, 16'hffff));
        add_row(point_row(SIDE_RIGHT, 16'h0000, 16'h0000, 16'h1234));
        add_row(trim_row(SIDE_LEFT, 16'h0000, 16'h0000, 16'h0000,
                         1'b1, 2, 1, 1'b0, 1'b0));
        // diagonals across the full range
        add_row(point_row(SIDE_LEFT, 16'h8000, 16'h8000, 16'h0001));
        add_row(point_row(SIDE_LEFT, 16'h7fff, 16'h7fff, 16'h0002));
        add_row(point_row(SIDE_LEFT, 16'h0000, 16'h7fff, 16'h0003));
        add_row(point_row(SIDE_RIGHT, 16'h8000, 16'h7fff, 16'h0004));
        add_row(point_row(SIDE_RIGHT, 16'h7fff, 16'h8000, 16'h0005));
        add_row(trim_row(SIDE_RIGHT, 16'h5555, 16'haaaa, 16'h00ff,
                         1'b0, 0, 0, 1'b0, 1'b0));
        // touching and collinear segments
        add_row(point_row(SIDE_LEFT, 16'sd0, 16'sd0, 16'h0010));
        add_row(point_row(SIDE_LEFT, 16'sd10, 16'sd0, 16'h0011));
        add_row(point_row(SIDE_RIGHT, 16'sd5, 16'sd0, 16'h0020));
        add_row(point_row(SIDE_RIGHT, 16'sd5, 16'sd10, 16'h0021));
        add_row(point_row(SIDE_RIGHT, 16'sd20, 16'sd0, 16'h0022));
        add_row(point_row(SIDE_RIGHT, -16'sd5, 16'sd0, 16'h0023));
        add_row(trim_row(SIDE_LEFT, 16'haaaa, 16'h5555, 16'hff00,
                         1'b1, 2, 4, 1'b0, 1'b0));
        // crossing on the second left segment
        add_row(point_row(SIDE_LEFT, -16'sd50, -16'sd50, 16'h0030));
        add_row(point_row(SIDE_LEFT, -16'sd50, 16'sd50, 16'h0031));
        add_row(point_row(SIDE_LEFT, 16'sd50, 16'sd50, 16'h0032));
        add_row(point_row(SIDE_LEFT, 16'sd50, -16'sd50, 16'h0033));
        add_row(point_row(SIDE_RIGHT, 16'sd0, 16'sd100, 16'hfffe));
        add_row(point_row(SIDE_RIGHT, 16'sd0, -16'sd100, 16'hffff));
        add_row(trim_row(SIDE_RIGHT, 16'h0000, 16'h0000, 16'h0000,
                         1'b0, 0, 0, 1'b0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_item(directed[k]);
        wait_for_drain();

        random_base = n_items;
        random_lines(1'b1);
        while (n_items - random_base < RANDOM_ITEMS)
        begin
            random_lines(1'b0);
            n_seq++;
            if (n_seq == 10)
                wait_for_drain();
        end
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d items sent (%0d directed), %0d results checked",
                 n_items, directed.size(), n_results);
        $display("%0d trims: %0d crossing, %0d with dropped points, %0d nodes removed",
                 n_trims, n_crossed, n_overflowed, n_removed);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== polyline_crossing_trim.f =====
rtl/core/pct_pkg.sv
rtl/core/pct_ram.sv
rtl/core/pct_cross.sv
rtl/core/polyline_crossing_trim.sv
tb/polyline_crossing_trim_tb.sv
